// File: rtl/vtpc_pkg.sv
// Shared types, widths and codes for the vertex transform, projection and clip unit.
package vtpc_pkg;

    localparam int PT_W     = 20;
    localparam int DIFF_W   = 21;
    localparam int COEF_W   = 20;
    localparam int PROD_W   = 41;
    localparam int SUM_W    = 43;
    localparam int CAM_W    = 40;
    localparam int SCR_W    = 32;
    localparam int NUM_W    = 56;
    localparam int QUO_W    = 34;
    localparam int ZS_W     = 51;
    localparam int REG60_W  = 60;
    localparam int REG31_W  = 31;
    localparam int REG20_W  = 20;
    localparam int DIM_W    = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [REG31_W-1:0] NEAR_PROJ_RST = 31'd164;
    localparam logic [REG31_W-1:0] NEAR_CODE_RST = 31'd262144;
    localparam logic [REG20_W-1:0] SCREEN_RST    = 20'd205120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_H    = 3'd0,
        REG_ROW_Z    = 3'd1,
        REG_ROW_V    = 3'd2,
        REG_CAM_POS  = 3'd3,
        REG_NEAR_PRJ = 3'd4,
        REG_NEAR_COD = 3'd5,
        REG_SCREEN   = 3'd6
    } cfg_idx_t;

    localparam int CC_LEFT   = 0;
    localparam int CC_RIGHT  = 1;
    localparam int CC_TOP    = 2;
    localparam int CC_BOTTOM = 3;
    localparam int CC_REAR   = 4;

    // sideband that rides along the divider
    typedef struct packed {
        logic                     mode;
        logic signed [CAM_W-1:0]  cx;
        logic signed [CAM_W-1:0]  cy;
        logic signed [CAM_W-1:0]  cz;
        logic                     scr_ok;
        logic                     scr_sel;
        logic                     behind;
        logic signed [ZS_W-1:0]   zw;
        logic signed [ZS_W-1:0]   zh;
    } side_t;

endpackage

// File: rtl/vtpc_dot.sv
// Three-stage translate and 3x3 matrix multiply with saturation to camera width.
module vtpc_dot (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic                                 in_mode,
    input  logic signed [vtpc_pkg::PT_W-1:0]     in_x,
    input  logic signed [vtpc_pkg::PT_W-1:0]     in_y,
    input  logic signed [vtpc_pkg::PT_W-1:0]     in_z,
    input  logic [vtpc_pkg::REG60_W-1:0]         row_h,
    input  logic [vtpc_pkg::REG60_W-1:0]         row_z,
    input  logic [vtpc_pkg::REG60_W-1:0]         row_v,
    input  logic [vtpc_pkg::REG60_W-1:0]         cam_pos,
    output logic                                 out_valid,
    output logic                                 out_mode,
    output logic signed [vtpc_pkg::CAM_W-1:0]    out_cx,
    output logic signed [vtpc_pkg::CAM_W-1:0]    out_cy,
    output logic signed [vtpc_pkg::CAM_W-1:0]    out_cz
);
    import vtpc_pkg::*;

    logic [2:0] vld_reg;
    logic [2:0] mode_reg;

    logic signed [DIFF_W-1:0] d_reg  [3];
    logic signed [DIFF_W-1:0] d_next [3];
    logic signed [PROD_W-1:0] p_reg  [9];
    logic signed [PROD_W-1:0] p_next [9];
    logic signed [CAM_W-1:0]  c_reg  [3];
    logic signed [CAM_W-1:0]  c_next [3];
    logic signed [PT_W-1:0]   pin    [3];
    logic signed [COEF_W-1:0] coef   [9];
    logic signed [SUM_W-1:0]  s      [3];

    localparam logic signed [SUM_W-1:0] CMAX = SUM_W'({1'b0, {(CAM_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

    assign pin[0] = in_x;
    assign pin[1] = in_y;
    assign pin[2] = in_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            coef[k]     = $signed(row_h[20*k +: COEF_W]);
            coef[3 + k] = $signed(row_v[20*k +: COEF_W]);
            coef[6 + k] = $signed(row_z[20*k +: COEF_W]);
            if (in_mode) begin
                d_next[k] = DIFF_W'(pin[k]);
            end else begin
                d_next[k] = DIFF_W'(pin[k]) - DIFF_W'($signed(cam_pos[20*k +: PT_W]));
            end
        end
        for (int j = 0; j < 9; j++) begin
            p_next[j] = PROD_W'(coef[j]) * PROD_W'(d_reg[j % 3]);
        end
        for (int r = 0; r < 3; r++) begin
            s[r] = SUM_W'(p_reg[3*r]) + SUM_W'(p_reg[3*r + 1]) + SUM_W'(p_reg[3*r + 2]);
            if (s[r] > CMAX) begin
                c_next[r] = CMAX[CAM_W-1:0];
            end else if (s[r] < CMIN) begin
                c_next[r] = CMIN[CAM_W-1:0];
            end else begin
                c_next[r] = s[r][CAM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg <= {mode_reg[1:0], in_mode};
            d_reg    <= d_next;
            p_reg    <= p_next;
            c_reg    <= c_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_mode  = mode_reg[2];
    assign out_cx    = c_reg[0];
    assign out_cy    = c_reg[1];
    assign out_cz    = c_reg[2];

endmodule

// File: rtl/vtpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two numerators over one divisor.
module vtpc_div #(
    parameter int SIDE_W = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [vtpc_pkg::NUM_W-1:0]         in_nx,
    input  logic [vtpc_pkg::NUM_W-1:0]         in_ny,
    input  logic [vtpc_pkg::CAM_W-1:0]         in_den,
    input  logic [SIDE_W-1:0]                  in_side,
    output logic                               out_valid,
    output logic [vtpc_pkg::QUO_W-1:0]         out_qx,
    output logic [vtpc_pkg::QUO_W-1:0]         out_qy,
    output logic                               out_ovx,
    output logic                               out_ovy,
    output logic [SIDE_W-1:0]                  out_side
);
    import vtpc_pkg::*;

    localparam int RW = CAM_W + 1;

    logic              vld_reg  [QUO_W+1];
    logic [NUM_W-1:0]  nx_reg   [QUO_W+1];
    logic [NUM_W-1:0]  ny_reg   [QUO_W+1];
    logic [RW-1:0]     rx_reg   [QUO_W+1];
    logic [RW-1:0]     ry_reg   [QUO_W+1];
    logic [QUO_W-1:0]  qx_reg   [QUO_W+1];
    logic [QUO_W-1:0]  qy_reg   [QUO_W+1];
    logic              ovx_reg  [QUO_W+1];
    logic              ovy_reg  [QUO_W+1];
    logic [CAM_W-1:0]  den_reg  [QUO_W+1];
    logic [SIDE_W-1:0] side_reg [QUO_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg[0]   <= in_nx;
            ny_reg[0]   <= in_ny;
            rx_reg[0]   <= RW'(in_nx[NUM_W-1:QUO_W]);
            ry_reg[0]   <= RW'(in_ny[NUM_W-1:QUO_W]);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovx_reg[0]  <= CAM_W'(in_nx[NUM_W-1:QUO_W]) >= in_den;
            ovy_reg[0]  <= CAM_W'(in_ny[NUM_W-1:QUO_W]) >= in_den;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [RW-1:0] shx, shy, rx_next, ry_next;
        logic          gex, gey;

        always_comb begin
            shx     = {rx_reg[k-1][RW-2:0], nx_reg[k-1][QUO_W-k]};
            shy     = {ry_reg[k-1][RW-2:0], ny_reg[k-1][QUO_W-k]};
            gex     = shx >= {1'b0, den_reg[k-1]};
            gey     = shy >= {1'b0, den_reg[k-1]};
            rx_next = gex ? shx - {1'b0, den_reg[k-1]} : shx;
            ry_next = gey ? shy - {1'b0, den_reg[k-1]} : shy;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nx_reg[k]   <= nx_reg[k-1];
                ny_reg[k]   <= ny_reg[k-1];
                rx_reg[k]   <= rx_next;
                ry_reg[k]   <= ry_next;
                qx_reg[k]   <= {qx_reg[k-1][QUO_W-2:0], gex};
                qy_reg[k]   <= {qy_reg[k-1][QUO_W-2:0], gey};
                ovx_reg[k]  <= ovx_reg[k-1];
                ovy_reg[k]  <= ovy_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_qx    = qx_reg[QUO_W];
    assign out_qy    = qy_reg[QUO_W];
    assign out_ovx   = ovx_reg[QUO_W];
    assign out_ovy   = ovy_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// File: rtl/vertex_transform_project_clip_unit.sv
// Vertex transform, perspective projection and clip outcode: top level.
// One vertex enters and one result beat leaves per clock while the output is not held. A
// vertex passes the translate and matrix multiply, the division setup register, the
// one-bit-per-stage depth divider, and the centering/saturation and outcode registers.
// All stages advance together; when the output beat is held, the whole pipe holds
// and s_tready drops. Configuration is written through cfg_we/cfg_index/cfg_wdata;
// the user must do so only while no beats are in flight: the block does not enforce it.
module vertex_transform_project_clip_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,  // point_x, point_y, point_z
    input  logic                            s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [191:0]                    m_tdata,  // camera_x/y/z, screen_x/y, clip_codes
    output logic                            m_tuser,  // screen_valid
    input  logic                            cfg_we,
    input  logic [vtpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vtpc_pkg::REG60_W-1:0]    cfg_wdata
);
    import vtpc_pkg::*;

    localparam int SIDE_W = $bits(side_t);
    localparam int QS_W   = QUO_W + 2;

    logic [REG60_W-1:0] row_h_reg, row_z_reg, row_v_reg, cam_reg;
    logic [REG31_W-1:0] nprj_reg, ncod_reg;
    logic [REG20_W-1:0] scr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_h_reg <= '0;
            row_z_reg <= '0;
            row_v_reg <= '0;
            cam_reg   <= '0;
            nprj_reg  <= NEAR_PROJ_RST;
            ncod_reg  <= NEAR_CODE_RST;
            scr_reg   <= SCREEN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROW_H:    row_h_reg <= cfg_wdata;
                REG_ROW_Z:    row_z_reg <= cfg_wdata;
                REG_ROW_V:    row_v_reg <= cfg_wdata;
                REG_CAM_POS:  cam_reg   <= cfg_wdata;
                REG_NEAR_PRJ: nprj_reg  <= cfg_wdata[REG31_W-1:0];
                REG_NEAR_COD: ncod_reg  <= cfg_wdata[REG31_W-1:0];
                REG_SCREEN:   scr_reg   <= cfg_wdata[REG20_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv      = m_tready || !m_tvalid;
    assign s_tready = adv;

    logic                    t_valid, t_mode;
    logic signed [CAM_W-1:0] t_cx, t_cy, t_cz;

    vtpc_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_x      ($signed(s_tdata[19:0])),
        .in_y      ($signed(s_tdata[39:20])),
        .in_z      ($signed(s_tdata[59:40])),
        .row_h     (row_h_reg),
        .row_z     (row_z_reg),
        .row_v     (row_v_reg),
        .cam_pos   (cam_reg),
        .out_valid (t_valid),
        .out_mode  (t_mode),
        .out_cx    (t_cx),
        .out_cy    (t_cy),
        .out_cz    (t_cz)
    );

    logic [DIM_W-1:0] w, h;
    assign w = scr_reg[DIM_W-1:0];
    assign h = scr_reg[2*DIM_W-1:DIM_W];

    // division setup
    logic             p_valid_reg;
    logic [NUM_W-1:0] p_nx_reg, p_ny_reg, p_nx_next, p_ny_next;
    logic [CAM_W-1:0] p_den_reg;
    side_t            p_side_reg, p_side_next;
    logic             p_negx_reg, p_negy_reg;
    logic [CAM_W-1:0] magx, magy;
    logic             z_pos;

    always_comb begin
        z_pos = !t_cz[CAM_W-1] && (t_cz != '0);
        magx  = t_cx[CAM_W-1] ? CAM_W'(-t_cx) : CAM_W'(t_cx);
        magy  = t_cy[CAM_W-1] ? CAM_W'(-t_cy) : CAM_W'(t_cy);
        p_nx_next = {magx, 16'b0};
        p_ny_next = {magy, 16'b0};
        p_side_next.mode    = t_mode;
        p_side_next.cx      = t_cx;
        p_side_next.cy      = t_cy;
        p_side_next.cz      = t_cz;
        p_side_next.scr_ok  = !t_mode && z_pos && (t_cz >= $signed(CAM_W'(nprj_reg)));
        p_side_next.scr_sel = p_side_next.scr_ok && (t_cz >= $signed(CAM_W'(ncod_reg)));
        p_side_next.behind  = !z_pos;
        p_side_next.zw      = ZS_W'(t_cz) * ZS_W'($signed({1'b0, w}));
        p_side_next.zh      = ZS_W'(t_cz) * ZS_W'($signed({1'b0, h}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= t_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_nx_reg   <= p_nx_next;
            p_ny_reg   <= p_ny_next;
            p_den_reg  <= t_cz;
            p_side_reg <= p_side_next;
            p_negx_reg <= t_cx[CAM_W-1];
            p_negy_reg <= !t_cy[CAM_W-1] && (t_cy != '0);
        end
    end

    logic             d_valid, d_ovx, d_ovy;
    logic [QUO_W-1:0] d_qx, d_qy;
    logic [SIDE_W+1:0] d_side_raw;
    side_t            d_side;
    logic             d_negx, d_negy;

    vtpc_div #(
        .SIDE_W (SIDE_W + 2)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p_valid_reg),
        .in_nx     (p_nx_reg),
        .in_ny     (p_ny_reg),
        .in_den    (p_den_reg),
        .in_side   ({p_negx_reg, p_negy_reg, p_side_reg}),
        .out_valid (d_valid),
        .out_qx    (d_qx),
        .out_qy    (d_qy),
        .out_ovx   (d_ovx),
        .out_ovy   (d_ovy),
        .out_side  (d_side_raw)
    );

    assign d_negx = d_side_raw[SIDE_W+1];
    assign d_negy = d_side_raw[SIDE_W];
    assign d_side = d_side_raw[SIDE_W-1:0];

    // centering, saturation, camera-space compares
    localparam logic signed [QS_W-1:0] S32MAX = QS_W'(32'sh7FFFFFFF);
    localparam logic signed [QS_W-1:0] S32MIN = -S32MAX - QS_W'(1);

    logic                    a_valid_reg;
    side_t                   a_side_reg;
    logic signed [SCR_W-1:0] a_sx_reg, a_sy_reg, a_sx_next, a_sy_next;
    logic [4:0]              a_cam_reg, a_cam_next;
    logic signed [QS_W-1:0]  xc, yc, qsx, qsy, sumx, sumy;
    logic signed [ZS_W:0]    tx2, ty2, zw1, zh1;

    always_comb begin
        xc   = QS_W'($signed({1'b0, w, 15'b0})) - QS_W'(32768);
        yc   = QS_W'($signed({1'b0, h, 15'b0})) - QS_W'(32768);
        qsx  = d_negx ? -$signed(QS_W'(d_qx)) : $signed(QS_W'(d_qx));
        qsy  = d_negy ? -$signed(QS_W'(d_qy)) : $signed(QS_W'(d_qy));
        sumx = qsx + xc;
        sumy = qsy + yc;
        if (d_ovx) begin
            a_sx_next = d_negx ? S32MIN[SCR_W-1:0] : S32MAX[SCR_W-1:0];
        end else if (sumx > S32MAX) begin
            a_sx_next = S32MAX[SCR_W-1:0];
        end else if (sumx < S32MIN) begin
            a_sx_next = S32MIN[SCR_W-1:0];
        end else begin
            a_sx_next = sumx[SCR_W-1:0];
        end
        if (d_ovy) begin
            a_sy_next = d_negy ? S32MIN[SCR_W-1:0] : S32MAX[SCR_W-1:0];
        end else if (sumy > S32MAX) begin
            a_sy_next = S32MAX[SCR_W-1:0];
        end else if (sumy < S32MIN) begin
            a_sy_next = S32MIN[SCR_W-1:0];
        end else begin
            a_sy_next = sumy[SCR_W-1:0];
        end
        tx2 = (ZS_W+1)'(d_side.cx) <<< 1;
        ty2 = (ZS_W+1)'(d_side.cy) <<< 1;
        zw1 = (ZS_W+1)'(d_side.zw);
        zh1 = (ZS_W+1)'(d_side.zh);
        a_cam_next            = '0;
        a_cam_next[CC_REAR]   = d_side.behind;
        a_cam_next[CC_LEFT]   = tx2 < -zw1;
        a_cam_next[CC_RIGHT]  = tx2 > zw1;
        a_cam_next[CC_TOP]    = ty2 > zh1;
        a_cam_next[CC_BOTTOM] = ty2 < -zh1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_side_reg <= d_side;
            a_sx_reg   <= a_sx_next;
            a_sy_reg   <= a_sy_next;
            a_cam_reg  <= a_cam_next;
        end
    end

    // outcode select and output register
    localparam int BW = SCR_W + 2;
    logic                    o_valid_reg;
    logic signed [CAM_W-1:0] o_cx_reg, o_cy_reg, o_cz_reg;
    logic signed [SCR_W-1:0] o_sx_reg, o_sy_reg, o_sx_next, o_sy_next;
    logic                    o_sv_reg;
    logic [4:0]              o_cc_reg, o_cc_next;
    logic signed [BW-1:0]    bx, by, hb, lo;

    always_comb begin
        hb = BW'($signed({1'b0, w, 16'b0})) - BW'(32768);
        lo = -BW'(32768);
        bx = BW'(a_sx_reg);
        by = BW'(a_sy_reg);
        o_sx_next = a_side_reg.scr_ok ? a_sx_reg : '0;
        o_sy_next = a_side_reg.scr_ok ? a_sy_reg : '0;
        o_cc_next = '0;
        if (a_side_reg.mode) begin
            o_cc_next = '0;
        end else if (a_side_reg.scr_sel) begin
            if (bx < lo) begin
                o_cc_next[CC_LEFT] = 1'b1;
            end else if (bx > hb) begin
                o_cc_next[CC_RIGHT] = 1'b1;
            end
            if (by < lo) begin
                o_cc_next[CC_TOP] = 1'b1;
            end else if (by > BW'($signed({1'b0, h, 16'b0})) - BW'(32768)) begin
                o_cc_next[CC_BOTTOM] = 1'b1;
            end
        end else begin
            o_cc_next = a_cam_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            o_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_cx_reg <= a_side_reg.cx;
            o_cy_reg <= a_side_reg.cy;
            o_cz_reg <= a_side_reg.cz;
            o_sx_reg <= o_sx_next;
            o_sy_reg <= o_sy_next;
            o_sv_reg <= a_side_reg.scr_ok;
            o_cc_reg <= o_cc_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_sv_reg;
    assign m_tdata  = {3'b000, o_cc_reg, o_sy_reg, o_sx_reg, o_cz_reg, o_cy_reg, o_cx_reg};

endmodule

// File: rtl/vtpc_checker.sv
// Port-level checks for the vertex transform, projection and clip unit, with bind.
module vtpc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic         m_tuser
);
    a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("input ready does not follow output stall");

    a_noscr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[183:120] == 64'd0)
        else $error("screen position nonzero without screen valid");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind vertex_transform_project_clip_unit vtpc_checker u_vtpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/tb_vertex_transform_project_clip_unit.sv
// Self-checking testbench for the vertex transform, projection and clip unit.
module tb_vertex_transform_project_clip_unit;
    import vtpc_pkg::*;

    localparam int  LATENCY   = 41;
    localparam longint LIMIT  = 2000000;
    localparam longint CAMMAX = 64'sd549755813887;
    localparam longint CAMMIN = -64'sd549755813888;
    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    typedef struct packed {
        logic                 mode;
        logic [PT_W-1:0]      px;
        logic [PT_W-1:0]      py;
        logic [PT_W-1:0]      pz;
    } vertex_t;

    typedef struct packed {
        logic [CAM_W-1:0] cx;
        logic [CAM_W-1:0] cy;
        logic [CAM_W-1:0] cz;
        logic [SCR_W-1:0] sx;
        logic [SCR_W-1:0] sy;
        logic             valid;
        logic [4:0]       codes;
    } xform_t;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, s_tuser;
    logic [63:0] s_tdata;
    logic m_tvalid, m_tready, m_tuser;
    logic [191:0] m_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG60_W-1:0] cfg_wdata;

    // shadow of the block's registers
    logic [REG60_W-1:0] row_h, row_z, row_v, cam_pos;
    logic [REG31_W-1:0] near_prj, near_cod;
    logic [REG20_W-1:0] scr_size;

    vertex_t pending_vtx[$];
    xform_t  expected_xf[$];
    int      n_queued, n_accepted, n_errors;
    longint  cyc;
    int      tx_gap, rx_gap, hold_left;
    bit      tx_idle_en, rx_idle_en, hold_done, tx_taken;

    vertex_transform_project_clip_unit i_dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_we, .cfg_index, .cfg_wdata
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint lane(logic [REG60_W-1:0] r, int k);
        logic signed [PT_W-1:0] v;
        v = r[20*k +: 20];
        return longint'(v);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint row_dot(logic [REG60_W-1:0] r, longint d0, longint d1, longint d2);
        return clamp(lane(r, 0) * d0 + lane(r, 1) * d1 + lane(r, 2) * d2, CAMMIN, CAMMAX);
    endfunction

    function automatic xform_t transform_vertex(vertex_t v);
        xform_t res;
        longint d0, d1, d2, cx, cy, cz, sx, sy, w, h, zw, zh;
        logic   ok;
        logic [4:0] cc;
        logic signed [PT_W-1:0] ax, ay, az;
        ax = v.px; ay = v.py; az = v.pz;
        d0 = ax; d1 = ay; d2 = az;
        if (!v.mode) begin
            d0 -= lane(cam_pos, 0);
            d1 -= lane(cam_pos, 1);
            d2 -= lane(cam_pos, 2);
        end
        cx = row_dot(row_h, d0, d1, d2);
        cz = row_dot(row_z, d0, d1, d2);
        cy = row_dot(row_v, d0, d1, d2);
        sx = 0; sy = 0; ok = 1'b0; cc = '0;
        if (!v.mode) begin
            w = scr_size[9:0];
            h = scr_size[19:10];
            if (cz > 0 && cz >= longint'(near_prj)) begin
                ok = 1'b1;
                sx = clamp(cx * 65536 / cz + w * 32768 - 32768, I32MIN, I32MAX);
                sy = clamp((-cy) * 65536 / cz + h * 32768 - 32768, I32MIN, I32MAX);
            end
            if (ok && cz >= longint'(near_cod)) begin
                if (sx < -32768) cc[CC_LEFT] = 1'b1;
                else if (sx > w * 65536 - 32768) cc[CC_RIGHT] = 1'b1;
                if (sy < -32768) cc[CC_TOP] = 1'b1;
                else if (sy > h * 65536 - 32768) cc[CC_BOTTOM] = 1'b1;
            end else begin
                zw = cz * w;
                zh = cz * h;
                cc[CC_REAR]   = (cz <= 0);
                cc[CC_LEFT]   = (2 * cx < -zw);
                cc[CC_RIGHT]  = (2 * cx > zw);
                cc[CC_TOP]    = (2 * cy > zh);
                cc[CC_BOTTOM] = (2 * cy < -zh);
            end
        end
        res.cx = cx[CAM_W-1:0];
        res.cy = cy[CAM_W-1:0];
        res.cz = cz[CAM_W-1:0];
        res.sx = sx[SCR_W-1:0];
        res.sy = sy[SCR_W-1:0];
        res.valid = ok;
        res.codes = cc;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    always @(negedge aclk) begin
        logic nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tx_taken) begin
            tx_taken = 1'b0;
            nv = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_vtx.size() > 0) begin
                vertex_t v;
                v = pending_vtx.pop_front();
                s_tdata <= {4'b0, v.pz, v.py, v.px};
                s_tuser <= v.mode;
                nv = 1'b1;
                tx_gap = tx_idle_en ? pick_gap() : 0;
            end
            s_tvalid <= nv;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            vertex_t v;
            v.mode = s_tuser;
            v.px = s_tdata[19:0];
            v.py = s_tdata[39:20];
            v.pz = s_tdata[59:40];
            expected_xf.push_back(transform_vertex(v));
            n_accepted++;
            tx_taken = 1'b1;
        end
    end

    // receiver, with one long hold-off once traffic is flowing
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && n_accepted >= 125) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            rx_gap = rx_idle_en ? pick_gap() : 0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            xform_t got, want;
            got.cx = m_tdata[39:0];
            got.cy = m_tdata[79:40];
            got.cz = m_tdata[119:80];
            got.sx = m_tdata[151:120];
            got.sy = m_tdata[183:152];
            got.codes = m_tdata[188:184];
            got.valid = m_tuser;
            if (expected_xf.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                n_errors++;
            end else begin
                want = expected_xf.pop_front();
                if (got.cx !== want.cx)
                    $display("%0t: camera_x exp %h act %h", $time, want.cx, got.cx);
                if (got.cy !== want.cy)
                    $display("%0t: camera_y exp %h act %h", $time, want.cy, got.cy);
                if (got.cz !== want.cz)
                    $display("%0t: camera_z exp %h act %h", $time, want.cz, got.cz);
                if (got.sx !== want.sx)
                    $display("%0t: screen_x exp %h act %h", $time, want.sx, got.sx);
                if (got.sy !== want.sy)
                    $display("%0t: screen_y exp %h act %h", $time, want.sy, got.sy);
                if (got.valid !== want.valid)
                    $display("%0t: screen_valid exp %b act %b", $time, want.valid, got.valid);
                if (got.codes !== want.codes)
                    $display("%0t: clip_codes exp %b act %b", $time, want.codes, got.codes);
                if (got !== want) n_errors++;
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [REG60_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROW_H:    row_h    = val;
            REG_ROW_Z:    row_z    = val;
            REG_ROW_V:    row_v    = val;
            REG_CAM_POS:  cam_pos  = val;
            REG_NEAR_PRJ: near_prj = val[REG31_W-1:0];
            REG_NEAR_COD: near_cod = val[REG31_W-1:0];
            REG_SCREEN:   scr_size = val[REG20_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(logic [59:0] h, logic [59:0] z, logic [59:0] v, logic [59:0] cp,
                              logic [30:0] np, logic [30:0] nc, logic [19:0] ss);
        write_reg(REG_ROW_H, h);
        write_reg(REG_ROW_Z, z);
        write_reg(REG_ROW_V, v);
        write_reg(REG_CAM_POS, cp);
        write_reg(REG_NEAR_PRJ, {29'b0, np});
        write_reg(REG_NEAR_COD, {29'b0, nc});
        write_reg(REG_SCREEN, {40'b0, ss});
    endtask

    task automatic push_vtx(logic m, logic [19:0] x, logic [19:0] y, logic [19:0] z);
        vertex_t v;
        v.mode = m; v.px = x; v.py = y; v.pz = z;
        pending_vtx.push_back(v);
        n_queued++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_xf.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    function automatic logic [19:0] rand_coord(int style);
        case (style)
            0: return 20'($urandom);
            1: return 20'($signed($urandom_range(0, 8191)) - 4096);
            default: return $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
        endcase
    endfunction

    function automatic logic [19:0] coef(int c);
        return 20'(c);
    endfunction

    initial begin
        logic [59:0] rh, rz, rv, cp;
        int sty;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_ROW_H; cfg_wdata = '0;
        row_h = '0; row_z = '0; row_v = '0; cam_pos = '0;
        near_prj = NEAR_PROJ_RST; near_cod = NEAR_CODE_RST; scr_size = SCREEN_RST;
        n_queued = 0; n_accepted = 0; n_errors = 0; cyc = 0;
        tx_gap = 0; rx_gap = 0; hold_left = 0; hold_done = 1'b0; tx_taken = 1'b0;
        tx_idle_en = 1'b0; rx_idle_en = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset registers: zero matrix, every point lands at depth zero
        push_vtx(1'b0, 20'h7FFFF, 20'h80000, 20'h00001);
        push_vtx(1'b1, 20'h80000, 20'h7FFFF, 20'hFFFFF);
        drain();

        // identity with projection scale: x 10000, depth 1024, y 10000, camera at origin
        load_setup({coef(0), coef(0), coef(100 * 1024 / 1024 * 100)},
                   {coef(1024), coef(0), coef(0)} >> 0,
                   {coef(0), coef(100 * 100), coef(0)},
                   '0, 31'd164, 31'd262144, 20'd205120);
        // depth comes from z in lane 2
        load_setup({coef(0), coef(0), coef(10000)}, {coef(1024), coef(0), coef(0)},
                   {coef(0), coef(10000), coef(0)}, '0, 31'd164, 31'd262144, 20'd205120);
        push_vtx(1'b0, 20'd0, 20'd0, 20'd0);               // zero depth
        push_vtx(1'b0, 20'd16, 20'd16, 20'd16);            // depth 16384: near, camera coding
        push_vtx(1'b0, 20'd0, 20'd0, 20'd1024);            // far, on screen center
        push_vtx(1'b0, 20'd4000, 20'd0, 20'd1024);         // far, right of center
        push_vtx(1'b0, -20'sd4000, 20'd0, 20'd1024);       // far, left of center
        push_vtx(1'b0, 20'd0, 20'd3000, 20'd1024);         // far, above center
        push_vtx(1'b0, 20'd0, -20'sd3000, 20'd1024);       // far, below center
        push_vtx(1'b0, 20'd0, 20'd0, -20'sd64);            // behind
        push_vtx(1'b0, 20'h7FFFF, 20'h80000, 20'h7FFFF);
        push_vtx(1'b1, 20'h7FFFF, 20'h80000, 20'h7FFFF);
        push_vtx(1'b0, 20'd8, 20'd8, 20'd1);               // depth 1024: near, camera coding
        drain();

        // saturation, zero limits (coding limit equal to projection limit), zero screen size
        load_setup({3{20'h80000}}, {20'h00000, 20'h00000, 20'h7FFFF}, {3{20'h7FFFF}},
                   {20'h7FFFF, 20'h80000, 20'h7FFFF}, 31'd0, 31'd0, 20'd0);
        push_vtx(1'b0, 20'h80000, 20'h80000, 20'h80000);
        push_vtx(1'b0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        push_vtx(1'b1, 20'h80000, 20'h80000, 20'h80000);
        push_vtx(1'b0, 20'h7FFFF, 20'h80000, 20'h00000);
        push_vtx(1'b0, 20'h00001, 20'h00000, 20'h80001);
        drain();
        load_setup({coef(1), coef(0), coef(0)}, {coef(0), coef(1), coef(0)},
                   {coef(0), coef(0), coef(1)}, '0, 31'h7FFFFFFF, 31'h7FFFFFFF, 20'hFFFFF);
        push_vtx(1'b0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        push_vtx(1'b0, 20'h80000, 20'h80000, 20'h80000);
        drain();

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            tx_idle_en = (ph % 3) != 0;
            rx_idle_en = (ph % 4) != 1;
            if (ph % 3 == 2) begin
                rh = 60'({$urandom, $urandom});
                rz = 60'({$urandom, $urandom});
                rv = 60'({$urandom, $urandom});
                cp = 60'({$urandom, $urandom});
                load_setup(rh, rz, rv, cp, 31'($urandom), 31'($urandom), 20'($urandom));
            end else begin
                rh = {coef($signed($urandom_range(0, 400)) - 200),
                      coef($signed($urandom_range(0, 400)) - 200),
                      coef($urandom_range(2000, 200000))};
                rz = {coef($urandom_range(800, 1200)),
                      coef($signed($urandom_range(0, 200)) - 100),
                      coef($signed($urandom_range(0, 200)) - 100)};
                rv = {coef($signed($urandom_range(0, 400)) - 200),
                      coef($urandom_range(2000, 200000)),
                      coef($signed($urandom_range(0, 400)) - 200)};
                cp = {20'($signed($urandom_range(0, 2000)) - 1000),
                      20'($signed($urandom_range(0, 2000)) - 1000),
                      20'($signed($urandom_range(0, 2000)) - 1000)};
                load_setup(rh, rz, rv, cp, 31'($urandom_range(0, 40000)),
                           31'($urandom_range(0, 2000000)),
                           {10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023))});
            end
            for (int i = 0; i < 50; i++) begin
                sty = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
                push_vtx($urandom_range(0, 9) == 0, rand_coord(sty), rand_coord(sty),
                         rand_coord(sty));
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
